[rtl/core/lbat_pkg.sv]
package lbat_pkg;

  // Field widths of the request and result items
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned START_W = 7;
  localparam int unsigned TYPE_W  = 1;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned FIRST_W = 7;
  localparam int unsigned LEFT_W  = 8;

  // Request kinds (tuser on the slave side)
  localparam logic [TYPE_W-1:0] REQ_ALLOC = 1'b0;
  localparam logic [TYPE_W-1:0] REQ_FREE  = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_SHORT   = 2'd1;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC,
    S_SEAL,
    S_FREE,
    S_DONE
  } state_t;

endpackage

[rtl/core/linked_block_allocation_table.sv]
// Linked block allocation table: one busy bit and one next-block link per block.
// Slave channel (s_tvalid/s_tready/s_tdata/s_tuser) takes one request at a time:
// tuser selects allocate or free, tdata carries the block count and chain start.
// Master channel (m_tvalid/m_tready/m_tdata) returns one result per request:
// status, first block of a new chain, and free blocks left afterwards.
// Allocate scans the table from block 0, one entry per cycle through the table
// memory's read port; once the last block is found it seals the chain end, and
// then its result registers.
// Free walks the chain one link per cycle, freeing each busy block it reaches;
// the walk ends on a last link, on a link to a block that is not busy, or on
// the step limit.
// A zero count, a shortage or a bad start skips the table and changes nothing.
// The next request can be taken once the result registers and the state is idle.
// After rst the table runs a clearing pass that writes every entry free with an
// end link; s_tready stays low during that pass.
// The result sits in an output register: a new request is taken while it waits.
// While the receiver stalls a finished result, the next request holds in its
// final state until the output register frees up.
module linked_block_allocation_table #(
  parameter int unsigned NUM_BLOCKS = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [7:0] block_count, [14:8] chain_start, [15] zero
  input  logic [15:0] s_tdata,
  // [0] req_type
  input  logic [lbat_pkg::TYPE_W-1:0] s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [1:0] status, [8:2] first_block, [16:9] free_left, [23:17] zero
  output logic [23:0] m_tdata
);
  import lbat_pkg::*;

  localparam int unsigned BW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned CW = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned EW = BW + 2;

  // Entry layout: {busy, last, link}
  localparam logic [EW-1:0] FREE_ENTRY = {1'b0, 1'b1, {BW{1'b0}}};

  state_t state, state_next;

  logic [EW-1:0] mem [NUM_BLOCKS];
  logic [EW-1:0] rd_raw, fwd_data, rd_data;
  logic          fwd_hit;
  logic [BW-1:0] rd_addr, wa;
  logic [EW-1:0] wd;
  logic          we;

  logic [CW-1:0]      clr, scan, taken, steps, free_total;
  logic               chk_vld;
  logic [BW-1:0]      chk_addr, prev, first, cur;
  logic [COUNT_W-1:0] count_q;
  logic [STAT_W-1:0]  res_status;

  logic               acc, out_free, start_ok, rd_busy, rd_last;
  logic               found, last_find, walk_hit, walk_more, alloc_bad;
  logic [BW-1:0]      rd_link;
  logic [COUNT_W-1:0] in_count;
  logic [START_W-1:0] in_start;

  // Request fields and handshake terms
  assign in_count = s_tdata[COUNT_W-1:0];
  assign in_start = s_tdata[COUNT_W +: START_W];
  assign acc      = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);
  assign start_ok = 32'(in_start) < 32'(NUM_BLOCKS);
  assign alloc_bad = (in_count == '0) || (32'(in_count) > 32'(free_total));

  // Read data with write forwarding on a same-address collision
  assign rd_data = fwd_hit ? fwd_data : rd_raw;
  assign rd_busy = rd_data[EW-1];
  assign rd_last = rd_data[EW-2];
  assign rd_link = rd_data[BW-1:0];

  // Scan and walk decisions
  assign found     = (state == S_ALLOC) && chk_vld && !rd_busy;
  assign last_find = found && (32'(taken) + 32'd1 == 32'(count_q));
  assign walk_hit  = (state == S_FREE) && rd_busy && (32'(steps) < 32'(NUM_BLOCKS));
  assign walk_more = walk_hit && !rd_last;

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_raw   <= mem[rd_addr];
    fwd_hit  <= we && (wa == rd_addr);
    fwd_data <= wd;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (32'(clr) == 32'(NUM_BLOCKS) - 32'd1) state_next = S_IDLE;
      S_IDLE: begin
        if (acc) begin
          if (s_tuser == REQ_FREE) begin
            state_next = start_ok ? S_FREE : S_DONE;
          end else begin
            state_next = alloc_bad ? S_DONE : S_ALLOC;
          end
        end
      end
      S_ALLOC: if (last_find) state_next = S_SEAL;
      S_SEAL:  state_next = S_DONE;
      S_FREE:  if (!walk_more) state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Memory port control
  always_comb begin
    rd_addr = '0;
    we      = 1'b0;
    wa      = '0;
    wd      = FREE_ENTRY;
    unique case (state)
      S_CLEAR: begin
        we = 1'b1;
        wa = clr[BW-1:0];
      end
      S_IDLE: rd_addr = BW'(in_start);
      S_ALLOC: begin
        rd_addr = scan[BW-1:0];
        // link the previous block to the one just found
        if (found && (taken != '0)) begin
          we = 1'b1;
          wa = prev;
          wd = {1'b1, 1'b0, chk_addr};
        end
      end
      S_SEAL: begin
        we = 1'b1;
        wa = prev;
        wd = {1'b1, 1'b1, {BW{1'b0}}};
      end
      S_FREE: begin
        rd_addr = rd_link;
        if (walk_hit) begin
          we = 1'b1;
          wa = cur;
        end
      end
      S_DONE: rd_addr = '0;
      default: rd_addr = '0;
    endcase
  end

  // Control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr        <= '0;
      m_tvalid   <= 1'b0;
      free_total <= CW'(NUM_BLOCKS);
      chk_vld    <= 1'b0;
    end else begin
      state <= state_next;
      // output register: load a finished result, else drop it once taken
      if ((state == S_DONE) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: clr <= clr + 1'b1;
        S_IDLE: begin
          if (acc) begin
            count_q <= in_count;
            scan    <= '0;
            chk_vld <= 1'b0;
            taken   <= '0;
            first   <= '0;
            steps   <= '0;
            cur     <= BW'(in_start);
            if (s_tuser == REQ_FREE) begin
              res_status <= start_ok ? ST_DONE : ST_INVALID;
            end else if (in_count == '0) begin
              res_status <= ST_INVALID;
            end else if (alloc_bad) begin
              res_status <= ST_SHORT;
            end else begin
              res_status <= ST_DONE;
            end
          end
        end
        S_ALLOC: begin
          // issue one read per cycle, check the one issued last cycle
          chk_vld  <= 32'(scan) < 32'(NUM_BLOCKS);
          chk_addr <= scan[BW-1:0];
          if (32'(scan) < 32'(NUM_BLOCKS)) begin
            scan <= scan + 1'b1;
          end
          if (found) begin
            if (taken == '0) begin
              first <= chk_addr;
            end
            prev  <= chk_addr;
            taken <= taken + 1'b1;
          end
        end
        S_SEAL: free_total <= free_total - taken;
        S_FREE: begin
          if (walk_hit) begin
            free_total <= free_total + 1'b1;
            steps      <= steps + 1'b1;
            cur        <= rd_link;
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_tdata <= {7'b0, LEFT_W'(free_total), FIRST_W'(first), res_status};
          end
        end
        default: clr <= clr;
      endcase
    end
  end

endmodule
